FILE: hw/rtl/hsoc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsoc_pkg
// Types and constants shared by the heading steering / obstacle controller.
// ----------------------------------------------------------------------------
package hsoc_pkg;

	// Field widths
	localparam int HEAD_W  = 12;
	localparam int GAIN_W  = 7;
	localparam int PULSE_W = 16;
	localparam int RANGE_W = 16;
	localparam int HOLD_W  = 8;

	// Wrapped heading error fits in +/-1800
	localparam int ERR_W   = 12;
	// Gain premultiplied by the divide-by-10 reciprocal
	localparam int GM_W    = 26;
	localparam int PROD_W  = 39;
	localparam int QUO_W   = 16;
	localparam int SUM_W   = 18;

	// Behavior constants
	localparam int NEAR_CM      = 50;
	localparam int PARTIAL_FWD  = 3200;
	localparam int WRAP_HALF    = 1800;
	localparam int WRAP_FULL    = 3600;
	localparam int HOLD_RIGHT   = 65;
	localparam int HOLD_REVERSE = 150;
	localparam int HOLD_LEFT    = 50;

	// floor(y / 10) = (y * RECIP_DIV10) >> RECIP_SHIFT, exact for y < 699050
	localparam int     RECIP_DIV10 = 419431;
	localparam int     RECIP_SHIFT = 22;
	// Offset that keeps the dividend non-negative: 10 * DIV_BIAS > 1800 * 127
	localparam int     DIV_BIAS    = 23000;
	localparam longint BIAS_SCALED = longint'(DIV_BIAS) * 10 * longint'(RECIP_DIV10);

	// Register reset values
	localparam int TARGET_RST  = 1800;
	localparam int GAIN_RST    = 10;
	localparam int CENTER_RST  = 2805;
	localparam int SMIN_RST    = 2185;
	localparam int SMAX_RST    = 3275;
	localparam int DSTOP_RST   = 2765;
	localparam int DREV_RST    = 2028;
	localparam int DFWD_RST    = 3400;

	// Register map, index = paddr[4:2]
	typedef enum logic [2:0] {
		REG_TARGET  = 3'd0,
		REG_GAIN    = 3'd1,
		REG_CENTER  = 3'd2,
		REG_SMIN    = 3'd3,
		REG_SMAX    = 3'd4,
		REG_DSTOP   = 3'd5,
		REG_DREV    = 3'd6,
		REG_DFWD    = 3'd7
	} reg_idx_t;

	// Avoidance stage
	typedef enum logic [1:0] {
		STG_RIGHT   = 2'd0,
		STG_REVERSE = 2'd1,
		STG_STOP    = 2'd2
	} stage_t;

	typedef struct packed {
		logic [HEAD_W-1:0]  target;
		logic [GM_W-1:0]    gm;
		logic [PULSE_W-1:0] center;
		logic [PULSE_W-1:0] steer_min;
		logic [PULSE_W-1:0] steer_max;
	} steer_cfg_t;

endpackage
`default_nettype wire

FILE: hw/rtl/heading_steer_obstacle_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// heading_steer_obstacle_controller
// Range/heading in, drive and steering commands out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries range_cm and heading_now.
//   Output channel (out_valid / out_stall) carries drive_pulse, steer_pulse,
//   hold_ticks and last_of_run. Most items give one result; a near reading
//   in the reverse stage gives two, the second flagged by last_of_run.
//   The input register loads at the accept edge, the product register
//   (heading error times gain) when the item moves on, and the result
//   register after that.
//   One item is accepted every cycle unless out_stall or a pending second
//   result holds the flow; items behind a two-result item wait in place.
//   The result register is the only point where out_stall acts; while it
//   holds, earlier stages fill and then raise in_stall.
//   Registers sit on an APB-style port at byte address 4*index, pready is
//   always high. Write them only while no item is in flight.
//   Reset empties the pipeline, loads the register defaults, sets the
//   avoidance stage to zero and the held steering to the center width.
// ----------------------------------------------------------------------------
module heading_steer_obstacle_controller (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] range_cm,
	input  logic [11:0] heading_now,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] drive_pulse,
	output logic [15:0] steer_pulse,
	output logic [7:0]  hold_ticks,
	output logic        last_of_run,

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import hsoc_pkg::*;

	typedef struct packed {
		logic [PULSE_W-1:0] drive;
		logic [PULSE_W-1:0] steer;
		logic [HOLD_W-1:0]  hold;
		logic               last;
		logic               two;
	} result_t;

	// Configuration registers
	logic [HEAD_W-1:0]  target_q;
	logic [GAIN_W-1:0]  gain_q;
	logic [GM_W-1:0]    gm_q;
	logic [PULSE_W-1:0] center_q;
	logic [PULSE_W-1:0] smin_q;
	logic [PULSE_W-1:0] smax_q;
	logic [PULSE_W-1:0] dstop_q;
	logic [PULSE_W-1:0] drev_q;
	logic [PULSE_W-1:0] dfwd_q;

	logic     wr_en;
	reg_idx_t reg_idx;

	// Pipeline
	logic               valid_s1;
	logic [RANGE_W-1:0] range_s1;
	logic [HEAD_W-1:0]  heading_s1;
	logic               valid_s2;
	logic [RANGE_W-1:0] range_s2;

	logic               out_valid_q;
	logic               pend_q;
	logic [PULSE_W-1:0] drive_q;
	logic [PULSE_W-1:0] steer_q;
	logic [HOLD_W-1:0]  hold_q;
	logic               last_q;

	stage_t             stage_q;
	stage_t             stage_d;
	logic [PULSE_W-1:0] steer_hold_q;
	logic [PULSE_W-1:0] steer_hold_d;

	logic               out_free;
	logic               s2_move;
	logic               s2_free;
	logic               s1_move;
	logic               near;
	logic [PULSE_W-1:0] steer_val;
	steer_cfg_t         steer_cfg;
	result_t            res;

	// ------------------------------------------------------------------
	// Configuration port
	// ------------------------------------------------------------------
	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= HEAD_W'(TARGET_RST);
			gain_q   <= GAIN_W'(GAIN_RST);
			gm_q     <= GM_W'(GAIN_RST * RECIP_DIV10);
			center_q <= PULSE_W'(CENTER_RST);
			smin_q   <= PULSE_W'(SMIN_RST);
			smax_q   <= PULSE_W'(SMAX_RST);
			dstop_q  <= PULSE_W'(DSTOP_RST);
			drev_q   <= PULSE_W'(DREV_RST);
			dfwd_q   <= PULSE_W'(DFWD_RST);
		end else if (wr_en) begin
			case (reg_idx)
				REG_TARGET: target_q <= pwdata[HEAD_W-1:0];
				REG_GAIN: begin
					gain_q <= pwdata[GAIN_W-1:0];
					// keep the gain premultiplied by the reciprocal of 10
					gm_q   <= GM_W'(32'(pwdata[GAIN_W-1:0]) * 32'(RECIP_DIV10));
				end
				REG_CENTER: center_q <= pwdata[PULSE_W-1:0];
				REG_SMIN:   smin_q   <= pwdata[PULSE_W-1:0];
				REG_SMAX:   smax_q   <= pwdata[PULSE_W-1:0];
				REG_DSTOP:  dstop_q  <= pwdata[PULSE_W-1:0];
				REG_DREV:   drev_q   <= pwdata[PULSE_W-1:0];
				REG_DFWD:   dfwd_q   <= pwdata[PULSE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_TARGET: prdata = 32'(target_q);
			REG_GAIN:   prdata = 32'(gain_q);
			REG_CENTER: prdata = 32'(center_q);
			REG_SMIN:   prdata = 32'(smin_q);
			REG_SMAX:   prdata = 32'(smax_q);
			REG_DSTOP:  prdata = 32'(dstop_q);
			REG_DREV:   prdata = 32'(drev_q);
			REG_DFWD:   prdata = 32'(dfwd_q);
			default:    prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Flow control
	// ------------------------------------------------------------------
	assign out_free = !out_valid_q || !out_stall;
	assign s2_move  = valid_s2 && out_free && !pend_q;
	assign s2_free  = !valid_s2 || s2_move;
	assign s1_move  = valid_s1 && s2_free;
	assign in_stall = valid_s1 && !s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (s2_free) begin
				valid_s2 <= s1_move;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			range_s1   <= range_cm;
			heading_s1 <= heading_now;
		end
		if (s1_move) begin
			range_s2 <= range_s1;
		end
	end

	// ------------------------------------------------------------------
	// Steering arithmetic
	// ------------------------------------------------------------------
	assign steer_cfg = '{
		target:    target_q,
		gm:        gm_q,
		center:    center_q,
		steer_min: smin_q,
		steer_max: smax_q
	};

	hsoc_steer u_steer (
		.clk       (clk),
		.load      (s1_move),
		.heading   (heading_s1),
		.cfg       (steer_cfg),
		.steer_val (steer_val)
	);

	// ------------------------------------------------------------------
	// Avoidance stage
	// ------------------------------------------------------------------
	assign near = range_s2 < RANGE_W'(NEAR_CM);

	always_comb begin
		stage_d      = stage_q;
		steer_hold_d = steer_hold_q;
		if (!near) begin
			stage_d      = STG_RIGHT;
			steer_hold_d = steer_val;
		end else begin
			case (stage_q)
				STG_RIGHT: begin
					stage_d      = STG_REVERSE;
					steer_hold_d = smax_q;
				end
				STG_REVERSE: begin
					stage_d      = STG_STOP;
					steer_hold_d = smin_q;
				end
				default: ;
			endcase
		end
	end

	// First result of the item in stage 2; a second one follows when two is set
	always_comb begin
		res = '{drive: dstop_q, steer: steer_hold_q, hold: '0, last: 1'b1, two: 1'b0};
		if (!near) begin
			res = '{drive: dfwd_q, steer: steer_val, hold: '0, last: 1'b1, two: 1'b0};
		end else begin
			case (stage_q)
				STG_RIGHT: res = '{drive: PULSE_W'(PARTIAL_FWD), steer: smax_q,
					hold: HOLD_W'(HOLD_RIGHT), last: 1'b1, two: 1'b0};
				STG_REVERSE: res = '{drive: drev_q, steer: steer_hold_q,
					hold: HOLD_W'(HOLD_REVERSE), last: 1'b0, two: 1'b1};
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q      <= STG_RIGHT;
			steer_hold_q <= PULSE_W'(CENTER_RST);
		end else if (s2_move) begin
			stage_q      <= stage_d;
			steer_hold_q <= steer_hold_d;
		end
	end

	// ------------------------------------------------------------------
	// Result register with one pending follow-up result
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else if (out_free) begin
			if (pend_q) begin
				out_valid_q <= 1'b1;
				pend_q      <= 1'b0;
			end else begin
				out_valid_q <= valid_s2;
				pend_q      <= valid_s2 && res.two;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (pend_q) begin
				drive_q <= dfwd_q;
				steer_q <= smin_q;
				hold_q  <= HOLD_W'(HOLD_LEFT);
				last_q  <= 1'b1;
			end else if (valid_s2) begin
				drive_q <= res.drive;
				steer_q <= res.steer;
				hold_q  <= res.hold;
				last_q  <= res.last;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign drive_pulse = drive_q;
	assign steer_pulse = steer_q;
	assign hold_ticks  = hold_q;
	assign last_of_run = last_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_pend_has_first: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (out_valid_q && !last_q))
		else $error("pending result without a first result shown");

	a_second_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_stall && !last_q) |=> (out_valid_q && last_q))
		else $error("second result did not follow the first");

	a_reverse_to_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_move && near && stage_q == STG_REVERSE) |=>
		(stage_q == STG_STOP && steer_hold_q == $past(smin_q)))
		else $error("reverse stage did not advance to stop");

	a_far_resets_stage: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_move && !near) |=> (stage_q == STG_RIGHT))
		else $error("far reading did not reset the stage");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_valid_q))
		else $error("input stalled with room in the pipeline");

endmodule
`default_nettype wire

FILE: hw/rtl/hsoc_steer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hsoc_steer
// Proportional steering: wrap the heading error, scale by gain, floor-divide
// by 10, add the center width and clamp. Product registered between halves.
// ----------------------------------------------------------------------------
module hsoc_steer (
	input  logic                        clk,
	input  logic                        load,
	input  logic [hsoc_pkg::HEAD_W-1:0] heading,
	input  hsoc_pkg::steer_cfg_t        cfg,
	output logic [hsoc_pkg::PULSE_W-1:0] steer_val
);
	import hsoc_pkg::*;

	logic signed [ERR_W+1:0]  err_raw;
	logic signed [ERR_W+1:0]  err_hi;
	logic signed [ERR_W+1:0]  err_wrap;
	logic signed [ERR_W-1:0]  err_w;
	logic signed [PROD_W-1:0] product_s2;
	logic        [PROD_W-1:0] scaled;
	logic        [QUO_W-1:0]  quo_biased;
	logic signed [SUM_W-1:0]  sum_raw;
	logic signed [SUM_W-1:0]  sum_lo;
	logic signed [SUM_W-1:0]  sum_clamp;

	// Each wrap correction is applied once
	always_comb begin
		err_raw = $signed({2'b00, cfg.target}) - $signed({2'b00, heading});
		err_hi = err_raw;
		if (err_raw > $signed((ERR_W+2)'(WRAP_HALF))) begin
			err_hi = err_raw - $signed((ERR_W+2)'(WRAP_FULL));
		end
		err_wrap = err_hi;
		if (err_hi < -$signed((ERR_W+2)'(WRAP_HALF))) begin
			err_wrap = err_hi + $signed((ERR_W+2)'(WRAP_FULL));
		end
		err_w = $signed(err_wrap[ERR_W-1:0]);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			product_s2 <= PROD_W'(err_w) * PROD_W'($signed({1'b0, cfg.gm}));
		end
	end

	// Biased dividend is non-negative, so the shift gives the floor
	always_comb begin
		scaled     = $unsigned(product_s2 + $signed(PROD_W'(BIAS_SCALED)));
		quo_biased = scaled[RECIP_SHIFT +: QUO_W];
		sum_raw    = $signed({2'b00, quo_biased}) + $signed({2'b00, cfg.center})
			- $signed(SUM_W'(DIV_BIAS));
		sum_lo = sum_raw;
		if (sum_raw < $signed({2'b00, cfg.steer_min})) begin
			sum_lo = $signed({2'b00, cfg.steer_min});
		end
		sum_clamp = sum_lo;
		if (sum_lo > $signed({2'b00, cfg.steer_max})) begin
			sum_clamp = $signed({2'b00, cfg.steer_max});
		end
		steer_val = sum_clamp[PULSE_W-1:0];
	end

endmodule
`default_nettype wire
